### rtl/dastore_pkg.sv
// Shared types, codes and the microprogram for the dynamic array store.
`timescale 1ns / 1ps

package dastore_pkg;

  // Field widths of the stream beats.
  localparam int MODE_W     = 2;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int POS_W      = 5;
  localparam int COUNT_W    = 6;
  localparam int CAPO_W     = 6;
  localparam int OUT_DATA_W = 24;

  // Operation codes carried on the input tuser.
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIND   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

  typedef logic [3:0] step_t;

  // Microprogram step addresses.
  localparam step_t S_WAIT     = 4'd0;
  localparam step_t S_DISPATCH = 4'd1;
  localparam step_t S_APPEND   = 4'd2;
  localparam step_t S_SCAN_RD  = 4'd3;
  localparam step_t S_SCAN_CMP = 4'd4;
  localparam step_t S_FOUND    = 4'd5;
  localparam step_t S_SHIFT_RD = 4'd6;
  localparam step_t S_SHIFT_WR = 4'd7;
  localparam step_t S_SHRINK   = 4'd8;
  localparam step_t S_MISS     = 4'd9;
  localparam step_t S_OUT_WAIT = 4'd10;
  localparam step_t S_EMIT     = 4'd11;

  // Datapath actions.
  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_LATCH,
    ACT_APPEND,
    ACT_READ,
    ACT_STEP,
    ACT_INC,
    ACT_SHIFT,
    ACT_SHRINK,
    ACT_MISS,
    ACT_EMIT
  } act_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_SEARCH,
    C_SCAN_END,
    C_NO_MATCH,
    C_FIND,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  // Status flags from the datapath that the sequencer branches on.
  typedef struct packed {
    logic no_in;
    logic search;
    logic scan_end;
    logic no_match;
    logic find;
    logic out_busy;
  } flags_t;

  function automatic ctrl_word_t ucode(input step_t step);
    ctrl_word_t w;
    w = '{act: ACT_NOP, cond: C_ALWAYS, target: S_WAIT};
    unique case (step)
      S_WAIT:     w = '{act: ACT_LATCH,  cond: C_NO_IN,    target: S_WAIT};
      S_DISPATCH: w = '{act: ACT_NOP,    cond: C_SEARCH,   target: S_SCAN_RD};
      S_APPEND:   w = '{act: ACT_APPEND, cond: C_ALWAYS,   target: S_OUT_WAIT};
      S_SCAN_RD:  w = '{act: ACT_READ,   cond: C_SCAN_END, target: S_MISS};
      S_SCAN_CMP: w = '{act: ACT_STEP,   cond: C_NO_MATCH, target: S_SCAN_RD};
      S_FOUND:    w = '{act: ACT_INC,    cond: C_FIND,     target: S_OUT_WAIT};
      S_SHIFT_RD: w = '{act: ACT_READ,   cond: C_SCAN_END, target: S_SHRINK};
      S_SHIFT_WR: w = '{act: ACT_SHIFT,  cond: C_ALWAYS,   target: S_SHIFT_RD};
      S_SHRINK:   w = '{act: ACT_SHRINK, cond: C_ALWAYS,   target: S_OUT_WAIT};
      S_MISS:     w = '{act: ACT_MISS,   cond: C_NEVER,    target: S_WAIT};
      S_OUT_WAIT: w = '{act: ACT_NOP,    cond: C_OUT_BUSY, target: S_OUT_WAIT};
      S_EMIT:     w = '{act: ACT_EMIT,   cond: C_ALWAYS,   target: S_WAIT};
      default:    w = '{act: ACT_NOP,    cond: C_ALWAYS,   target: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

### rtl/dastore_seq.sv
// Microprogram sequencer: step counter, control store and conditional jumps.
`timescale 1ns / 1ps

module dastore_seq
  import dastore_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  flags_t     flags,
  output ctrl_word_t ctrl
);

  step_t pc;
  step_t pc_next;
  logic  taken;

  assign ctrl = ucode(pc);

  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:    taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_NO_IN:    taken = flags.no_in;
      C_SEARCH:   taken = flags.search;
      C_SCAN_END: taken = flags.scan_end;
      C_NO_MATCH: taken = flags.no_match;
      C_FIND:     taken = flags.find;
      C_OUT_BUSY: taken = flags.out_busy;
      default:    taken = 1'b1;
    endcase
    pc_next = taken ? ctrl.target : pc + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

### rtl/dynamic_array_store.sv
// Top level of the dynamic array store: datapath, word memory and result register.
`timescale 1ns / 1ps
// Sequence: an append passes through the dispatch, append, output wait and emit steps; a find
// or remove reads and compares each entry scanned, and a remove also reads and writes each
// entry shifted. One item at a time: no new input beat is taken until the previous result has
// been emitted, and the single memory read port is used once per scanned or shifted entry.
// Reset (synchronous, active high) empties the list and sets the capacity to four;
// the word memory is not cleared, as only entries below the count are ever read.

module dynamic_array_store
  import dastore_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input beats.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [VALUE_W-1:0]    s_tdata,   // [31:0] value
  input  logic [MODE_W-1:0]     s_tuser,   // [1:0] mode
  // Result beats.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // [1:0] status, [6:2] position,
                                           // [12:7] count, [18:13] capacity, rest zero
);

  // The count must hold DEPTH itself; the capacity may double to just below 2*DEPTH.
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = $clog2(2 * DEPTH);
  localparam int CMP_W  = CAP_W + 2;

  ctrl_word_t ctrl;
  flags_t     flags;

  // Working registers of the current item.
  logic [MODE_W-1:0]   mode;
  logic [VALUE_W-1:0]  word;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    pos;
  logic [STATUS_W-1:0] status;

  // Architectural state.
  logic [CNT_W-1:0]    count;
  logic [CAP_W-1:0]    capacity;

  // Result register.
  logic [STATUS_W-1:0] res_status;
  logic [POS_W-1:0]    res_pos;
  logic [COUNT_W-1:0]  res_count;
  logic [CAPO_W-1:0]   res_cap;

  // Word memory with one write port and one registered read port.
  logic [VALUE_W-1:0]  mem [DEPTH];
  logic [VALUE_W-1:0]  rdata;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [VALUE_W-1:0]  mem_wdata;
  logic                mem_re;

  logic                is_full;
  logic                do_append;
  logic [CNT_W-1:0]    count_dec;
  logic [CMP_W-1:0]    count_dec_x4;
  logic [CAP_W-1:0]    cap_half;
  logic [CNT_W-1:0]    idx_prev;
  logic [CNT_W+POS_W-1:0]   pos_wide;
  logic [CNT_W+COUNT_W-1:0] count_wide;
  logic [CAP_W+CAPO_W-1:0]  cap_wide;

  dastore_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // The sequencer only waits for input in its first step, which also latches the beat.
  assign s_tready = (ctrl.act == ACT_LATCH);

  assign is_full   = (count >= CNT_W'(DEPTH));
  assign do_append = (ctrl.act == ACT_APPEND) && (mode == MODE_APPEND) && !is_full;
  assign idx_prev  = idx - CNT_W'(1);

  // Shrink rule: halve when four times the new count falls below the capacity,
  // but never let the capacity reach zero.
  assign count_dec    = count - CNT_W'(1);
  assign count_dec_x4 = {CAP_W'(count_dec), 2'b00};
  assign cap_half     = (capacity >> 1) == '0 ? CAP_W'(1) : (capacity >> 1);

  always_comb begin
    flags.no_in    = !s_tvalid;
    flags.search   = (mode == MODE_FIND) || (mode == MODE_REMOVE);
    flags.scan_end = (idx >= count);
    flags.no_match = (rdata != word);
    flags.find     = (mode == MODE_FIND);
    flags.out_busy = m_tvalid && !m_tready;
  end

  // Memory port control: appends write at the end, shifts write one place down.
  always_comb begin
    mem_re    = (ctrl.act == ACT_READ) && (idx < count);
    mem_we    = do_append || (ctrl.act == ACT_SHIFT);
    mem_waddr = (ctrl.act == ACT_SHIFT) ? idx_prev[ADDR_W-1:0] : count[ADDR_W-1:0];
    mem_wdata = (ctrl.act == ACT_SHIFT) ? rdata : word;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[idx[ADDR_W-1:0]];
    end
  end

  // Datapath registers, each updated by the action of the current step.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      capacity <= CAP_W'(4);
    end else begin
      unique case (ctrl.act)
        ACT_LATCH: begin
          if (s_tvalid) begin
            mode   <= s_tuser;
            word   <= s_tdata;
            idx    <= '0;
            pos    <= '0;
            status <= ST_OK;
          end
        end
        ACT_APPEND: begin
          if (mode == MODE_APPEND) begin
            if (is_full) begin
              status <= ST_FULL;
            end else begin
              if (CAP_W'(count) >= capacity) begin
                capacity <= capacity << 1;
              end
              count <= count + CNT_W'(1);
            end
          end
        end
        ACT_STEP: begin
          if (rdata == word) begin
            pos <= idx;
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end
        ACT_INC, ACT_SHIFT: begin
          idx <= idx + CNT_W'(1);
        end
        ACT_SHRINK: begin
          count <= count_dec;
          if (count_dec_x4 < CMP_W'(capacity)) begin
            capacity <= cap_half;
          end
        end
        ACT_MISS: begin
          status <= ST_MISSING;
          pos    <= '0;
        end
        ACT_NOP, ACT_READ, ACT_EMIT: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Fields are masked to their beat widths.
  assign pos_wide   = (CNT_W+POS_W)'(pos);
  assign count_wide = (CNT_W+COUNT_W)'(count);
  assign cap_wide   = (CAP_W+CAPO_W)'(capacity);

  // Result register: loaded only after the previous beat has left it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (ctrl.act == ACT_EMIT) begin
        m_tvalid   <= 1'b1;
        res_status <= status;
        res_pos    <= pos_wide[POS_W-1:0];
        res_count  <= count_wide[COUNT_W-1:0];
        res_cap    <= cap_wide[CAPO_W-1:0];
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {(OUT_DATA_W-STATUS_W-POS_W-COUNT_W-CAPO_W)'(0),
                    res_cap, res_count, res_pos, res_status};

  // The list never outgrows the memory.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above memory depth");

  // The capacity floor holds at all times.
  a_cap_nonzero: assert property (@(posedge clk) disable iff (rst)
    capacity != '0)
    else $error("capacity reached zero");

  // A result beat only appears from the emit step.
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(ctrl.act == ACT_EMIT))
    else $error("result beat raised outside the emit step");

  // The emit step never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (ctrl.act == ACT_EMIT) |-> (!m_tvalid || m_tready))
    else $error("result register overwritten while stalled");

  // An accepted append below the depth grows the list by exactly one.
  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    do_append |=> (count == $past(count) + CNT_W'(1)))
    else $error("append did not grow the list");

endmodule
